@@ hdl/trsu_pkg.sv @@
package trsu_pkg;

  // Width of every letter, index and position field
  localparam int FIELD_W = 5;

  // Default alphabet size
  localparam int ALPHABET_SIZE_DEF = 26;

  // Input item kinds (tuser bit 0)
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LETTER = 1'b1;

  // Rotor select codes for table loads
  localparam logic [1:0] ROTOR_FAST   = 2'd0;
  localparam logic [1:0] ROTOR_MIDDLE = 2'd1;
  localparam logic [1:0] ROTOR_SLOW   = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FAST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SLOW   = 2'd2;

  // Stream payload widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;

  // Table write request from the top level to one rotor
  typedef struct packed {
    logic               we;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] value;
  } trsu_wr_t;

endpackage

@@ hdl/trsu_rotor.sv @@
module trsu_rotor
  import trsu_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic               clk,
  input  trsu_wr_t           wr,
  input  logic [FIELD_W-1:0] c_in,   // < ALPHABET_SIZE
  input  logic [FIELD_W-1:0] pos,    // < ALPHABET_SIZE
  output logic [FIELD_W-1:0] c_out
);

  localparam int IDX_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [FIELD_W:0] N_EXT = (FIELD_W + 1)'(ALPHABET_SIZE);

  // Permutation table, undefined until loaded
  logic [FIELD_W-1:0] entries [ALPHABET_SIZE];

  logic [FIELD_W:0]   sum;
  logic [FIELD_W:0]   idx_mod;
  logic [FIELD_W-1:0] looked;
  logic [FIELD_W:0]   wrapped;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      entries[wr.idx[IDX_W-1:0]] <= wr.value;
    end
  end

  // (c + pos) mod N: both operands below N, so one subtract at most
  always_comb begin
    sum     = {1'b0, c_in} + {1'b0, pos};
    idx_mod = (sum >= N_EXT) ? (sum - N_EXT) : sum;
    looked  = entries[idx_mod[IDX_W-1:0]];
    wrapped = {1'b0, looked} + N_EXT - {1'b0, pos};
    c_out   = (looked >= pos) ? (looked - pos) : wrapped[FIELD_W-1:0];
  end

endmodule

@@ hdl/three_rotor_substitution_unit.sv @@
// Channel  | Direction | Signals                              | Contents
// s_axis   | in        | tvalid tready tdata[23:0] tuser[1:0] | table loads and letters
// m_axis   | out       | tvalid tready tdata[7:0]             | one letter per letter item
// cfg      | in        | valid ready index[1:0] data[4:0]     | rotor start positions
//
// One item per cycle sustained while m_axis accepts. A letter waits in the
// input register, where the three rotor passes (add, table read, subtract)
// run, until the result register is free; it reaches m_axis the next cycle.
// Loads write the rotor table as they leave the input register and give no
// output. Reset clears positions, start registers and valid flags; rotor
// tables are not cleared. A stalled m_axis holds letters only.
module three_rotor_substitution_unit
  import trsu_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] rotor_select, [6:2] table_index, [11:7] table_value, [16:12] letter
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] kind, [1] message_start
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [4:0] out_letter
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FIELD_W-1:0]    cfg_data
);

  localparam int RED_DEPTH = 2 ** FIELD_W;
  localparam logic [FIELD_W-1:0] N_LAST = FIELD_W'(ALPHABET_SIZE - 1);
  localparam logic [FIELD_W:0]   N_EXT  = (FIELD_W + 1)'(ALPHABET_SIZE);

  // Constant table: value mod alphabet size for every field value
  logic [FIELD_W-1:0] red_tab [RED_DEPTH];
  for (genvar g = 0; g < RED_DEPTH; g++) begin : g_red
    assign red_tab[g] = FIELD_W'(g % ALPHABET_SIZE);
  end

  // Input fields
  logic [1:0]         in_sel;
  logic [FIELD_W-1:0] in_idx;
  logic [FIELD_W-1:0] in_val;
  logic [FIELD_W-1:0] in_letter;
  logic               in_kind;
  logic               in_start;

  assign in_sel    = s_axis_tdata[1:0];
  assign in_idx    = s_axis_tdata[6:2];
  assign in_val    = s_axis_tdata[11:7];
  assign in_letter = s_axis_tdata[16:12];
  assign in_kind   = s_axis_tuser[0];
  assign in_start  = s_axis_tuser[1];

  // Start position registers
  logic [FIELD_W-1:0] start_fast;
  logic [FIELD_W-1:0] start_middle;
  logic [FIELD_W-1:0] start_slow;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_fast   <= '0;
      start_middle <= '0;
      start_slow   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_FAST:   start_fast   <= cfg_data;
        CFG_START_MIDDLE: start_middle <= cfg_data;
        CFG_START_SLOW:   start_slow   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake
  logic in_fire;
  logic out_free;
  logic s1_go;

  logic               s1_valid;
  logic               s1_kind;
  logic [1:0]         s1_sel;
  logic [FIELD_W-1:0] s1_idx;
  logic [FIELD_W-1:0] s1_val;
  logic [FIELD_W-1:0] s1_letter;
  logic [FIELD_W-1:0] s1_pf;
  logic [FIELD_W-1:0] s1_pm;
  logic [FIELD_W-1:0] s1_ps;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s1_go         = s1_valid && ((s1_kind == KIND_LOAD) || out_free);
  assign s_axis_tready = !s1_valid || s1_go;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Rotor positions: pick this letter's positions, then step the odometer
  logic [FIELD_W-1:0] pos_fast;
  logic [FIELD_W-1:0] pos_middle;
  logic [FIELD_W-1:0] pos_slow;
  logic [FIELD_W-1:0] eff_fast;
  logic [FIELD_W-1:0] eff_middle;
  logic [FIELD_W-1:0] eff_slow;
  logic [FIELD_W-1:0] pos_fast_next;
  logic [FIELD_W-1:0] pos_middle_next;
  logic [FIELD_W-1:0] pos_slow_next;

  always_comb begin
    eff_fast   = in_start ? red_tab[start_fast]   : pos_fast;
    eff_middle = in_start ? red_tab[start_middle] : pos_middle;
    eff_slow   = in_start ? red_tab[start_slow]   : pos_slow;

    pos_fast_next   = (eff_fast == N_LAST) ? '0 : eff_fast + 1'b1;
    pos_middle_next = eff_middle;
    pos_slow_next   = eff_slow;
    if (eff_fast == N_LAST) begin
      pos_middle_next = (eff_middle == N_LAST) ? '0 : eff_middle + 1'b1;
      if (eff_middle == N_LAST) begin
        pos_slow_next = (eff_slow == N_LAST) ? '0 : eff_slow + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_fast   <= '0;
      pos_middle <= '0;
      pos_slow   <= '0;
    end else if (in_fire && (in_kind == KIND_LETTER)) begin
      pos_fast   <= pos_fast_next;
      pos_middle <= pos_middle_next;
      pos_slow   <= pos_slow_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind   <= in_kind;
      s1_sel    <= in_sel;
      s1_idx    <= in_idx;
      s1_val    <= red_tab[in_val];
      s1_letter <= red_tab[in_letter];
      s1_pf     <= eff_fast;
      s1_pm     <= eff_middle;
      s1_ps     <= eff_slow;
    end
  end

  // Table writes, in item order as loads leave the input register
  logic     load_ok;
  trsu_wr_t wr_fast;
  trsu_wr_t wr_middle;
  trsu_wr_t wr_slow;

  always_comb begin
    load_ok = s1_go && (s1_kind == KIND_LOAD)
              && ({1'b0, s1_idx} < N_EXT)
              && (s1_sel inside {ROTOR_FAST, ROTOR_MIDDLE, ROTOR_SLOW});
    wr_fast   = '{we: load_ok && (s1_sel == ROTOR_FAST),   idx: s1_idx, value: s1_val};
    wr_middle = '{we: load_ok && (s1_sel == ROTOR_MIDDLE), idx: s1_idx, value: s1_val};
    wr_slow   = '{we: load_ok && (s1_sel == ROTOR_SLOW),   idx: s1_idx, value: s1_val};
  end

  // Rotor chain: slow, then middle, then fast
  logic [FIELD_W-1:0] c_slow;
  logic [FIELD_W-1:0] c_middle;
  logic [FIELD_W-1:0] c_fast;

  trsu_rotor #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_rotor_slow (
    .clk   (clk),
    .wr    (wr_slow),
    .c_in  (s1_letter),
    .pos   (s1_ps),
    .c_out (c_slow)
  );

  trsu_rotor #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_rotor_middle (
    .clk   (clk),
    .wr    (wr_middle),
    .c_in  (c_slow),
    .pos   (s1_pm),
    .c_out (c_middle)
  );

  trsu_rotor #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_rotor_fast (
    .clk   (clk),
    .wr    (wr_fast),
    .c_in  (c_middle),
    .pos   (s1_pf),
    .c_out (c_fast)
  );

  // Result register
  logic [FIELD_W-1:0] out_letter;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_go && (s1_kind == KIND_LETTER)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && (s1_kind == KIND_LETTER)) begin
      out_letter <= c_fast;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - FIELD_W){1'b0}}, out_letter};

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, pos_fast} < N_EXT) && ({1'b0, pos_middle} < N_EXT)
    && ({1'b0, pos_slow} < N_EXT))
    else $error("rotor position out of range");

  a_letter_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1_kind == KIND_LETTER) |=> m_axis_tvalid)
    else $error("letter left input register without a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !(s1_go && (s1_kind == KIND_LETTER)))
    else $error("result overwritten while stalled");

  a_load_no_out: assert property (@(posedge clk) disable iff (rst)
    s1_go && (s1_kind == KIND_LOAD) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("load item produced a result");
`endif

endmodule

@@ tb/sv/three_rotor_substitution_unit_test.sv @@
`timescale 1ns / 100ps

module three_rotor_substitution_unit_test;
  import trsu_pkg::*;

  localparam int ALPHA             = ALPHABET_SIZE_DEF;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int DRAIN_CYCLES      = 6;
  localparam int HOLD_CYCLES       = 300;
  localparam int HOLD_AFTER        = 100;
  localparam int LETTERS_PER_PHASE = 150;
  localparam int RANDOM_PHASES     = 5;
  localparam int DIR_ROWS          = 22;

  // Codes the package leaves unnamed
  localparam logic [1:0]           ROTOR_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  typedef logic [FIELD_W-1:0] field_t;

  typedef struct {
    logic       kind;
    logic [1:0] sel;
    field_t     idx;
    field_t     val;
    field_t     letter;
    logic       start;
    bit         typed;
    field_t     want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  field_t                cfg_data = '0;

  // Cipher state mirrored from accepted items
  field_t rotor_map [3][ALPHA];
  field_t start_reg [3] = '{default: '0};
  field_t rotor_pos [3] = '{default: '0};
  field_t expected_letters [$];

  int mismatch_count = 0;
  int letters_out = 0;
  int cycle_count = 0;
  bit sender_gaps_on = 1'b1;

  stim_row_t dir_rows [DIR_ROWS];

  three_rotor_substitution_unit #(
    .ALPHABET_SIZE(ALPHA)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short idles, now and then a long one
  function automatic int idle_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic field_t rand_field();
    return field_t'($urandom_range(0, 31));
  endfunction

  // Letters mostly in the alphabet, some above it
  function automatic field_t rand_letter();
    return ($urandom_range(0, 9) == 0) ? field_t'($urandom_range(26, 31))
                                       : field_t'($urandom_range(0, 25));
  endfunction

  // One rotor: shift in by position, look up, shift back out
  function automatic field_t rotor_pass(logic [1:0] rotor, int unsigned c, int unsigned pos);
    int unsigned entry;
    entry = rotor_map[rotor][(c + pos) % ALPHA] % ALPHA;
    return field_t'((entry + ALPHA - pos) % ALPHA);
  endfunction

  // Update the mirrored state for one item and queue the letter it yields
  task automatic track_item(input logic kind, input logic [1:0] sel, input field_t idx,
                            input field_t val, input field_t letter, input logic start,
                            input bit typed, input field_t want);
    field_t c;
    if (kind == KIND_LOAD) begin
      if (sel != ROTOR_NONE && idx < ALPHA)
        rotor_map[sel][idx] = field_t'(val % ALPHA);
    end else begin
      if (start) begin
        rotor_pos[ROTOR_FAST]   = field_t'(start_reg[ROTOR_FAST] % ALPHA);
        rotor_pos[ROTOR_MIDDLE] = field_t'(start_reg[ROTOR_MIDDLE] % ALPHA);
        rotor_pos[ROTOR_SLOW]   = field_t'(start_reg[ROTOR_SLOW] % ALPHA);
      end
      c = rotor_pass(ROTOR_SLOW, letter, rotor_pos[ROTOR_SLOW]);
      c = rotor_pass(ROTOR_MIDDLE, c, rotor_pos[ROTOR_MIDDLE]);
      c = rotor_pass(ROTOR_FAST, c, rotor_pos[ROTOR_FAST]);
      expected_letters.insert(expected_letters.size(), typed ? want : c);
      // Odometer step
      rotor_pos[ROTOR_FAST] = field_t'((rotor_pos[ROTOR_FAST] + 1) % ALPHA);
      if (rotor_pos[ROTOR_FAST] == 0) begin
        rotor_pos[ROTOR_MIDDLE] = field_t'((rotor_pos[ROTOR_MIDDLE] + 1) % ALPHA);
        if (rotor_pos[ROTOR_MIDDLE] == 0)
          rotor_pos[ROTOR_SLOW] = field_t'((rotor_pos[ROTOR_SLOW] + 1) % ALPHA);
      end
    end
  endtask

  // Offer one item; valid stays high into the next item when no gap follows
  task automatic send_item(input logic kind, input logic [1:0] sel, input field_t idx,
                           input field_t val, input field_t letter, input logic start,
                           input bit typed, input field_t want);
    int gap;
    s_axis_tdata  <= {{(IN_DATA_W - 17){1'b0}}, letter, val, idx, sel};
    s_axis_tuser  <= {start, kind};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    track_item(kind, sel, idx, val, letter, start, typed, want);
    if ($urandom_range(0, 99) == 0)
      sender_gaps_on = !sender_gaps_on;
    gap = (sender_gaps_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Full random permutation into one rotor
  task automatic reload_rotor(input logic [1:0] rotor);
    field_t perm [ALPHA];
    field_t t;
    int j;
    foreach (perm[i]) perm[i] = field_t'(i);
    for (int i = ALPHA - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    foreach (perm[i])
      send_item(KIND_LOAD, rotor, field_t'(i), perm[i], rand_field(),
                1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input field_t data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_FAST:   start_reg[ROTOR_FAST]   = data;
      CFG_START_MIDDLE: start_reg[ROTOR_MIDDLE] = data;
      CFG_START_SLOW:   start_reg[ROTOR_SLOW]   = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_starts(input field_t fast, input field_t middle, input field_t slow);
    cfg_write(CFG_START_FAST, fast);
    cfg_write(CFG_START_MIDDLE, middle);
    cfg_write(CFG_START_SLOW, slow);
  endtask

  // Stop offering, wait for every letter, then let a load in flight settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly letters, some stray loads, now and then a full rotor reload
  task automatic run_random_phase();
    int letters;
    int r;
    letters = 0;
    while (letters < LETTERS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        reload_rotor(2'($urandom_range(0, 2)));
      end else if (r < 10) begin
        send_item(KIND_LOAD, 2'($urandom_range(0, 3)), rand_field(), rand_field(),
                  rand_field(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        send_item(KIND_LETTER, 2'($urandom_range(0, 3)), rand_field(), rand_field(),
                  rand_letter(), (letters == 0) || ($urandom_range(0, 19) == 0), 1'b0, '0);
        letters++;
      end
    end
  endtask

  // Stimulus
  initial begin
    // Rows after the slow-rotor load are left to the predictor
    dir_rows = '{
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd0,  1'b1, 1'b1, 5'd0},
      '{KIND_LETTER, ROTOR_NONE,   5'd31, 5'd31, 5'd25, 1'b0, 1'b1, 5'd25},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd31, 1'b0, 1'b1, 5'd5},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd26, 1'b0, 1'b1, 5'd0},
      '{KIND_LOAD,   ROTOR_NONE,   5'd0,  5'd7,  5'd31, 1'b1, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_SLOW,   5'd13, 5'd2,  5'd0,  1'b0, 1'b1, 5'd0},
      '{KIND_LOAD,   ROTOR_FAST,   5'd31, 5'd9,  5'd0,  1'b0, 1'b0, 5'd0},
      '{KIND_LOAD,   ROTOR_FAST,   5'd26, 5'd9,  5'd0,  1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_MIDDLE, 5'd0,  5'd0,  5'd13, 1'b0, 1'b1, 5'd13},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd7,  1'b1, 1'b1, 5'd7},
      '{KIND_LOAD,   ROTOR_SLOW,   5'd0,  5'd31, 5'd0,  1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd0,  1'b1, 1'b0, 5'd0},
      '{KIND_LOAD,   ROTOR_FAST,   5'd25, 5'd26, 5'd0,  1'b0, 1'b0, 5'd0},
      '{KIND_LOAD,   ROTOR_MIDDLE, 5'd25, 5'd25, 5'd0,  1'b0, 1'b0, 5'd0},
      '{KIND_LOAD,   ROTOR_MIDDLE, 5'd0,  5'd0,  5'd0,  1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd25, 1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd31, 1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd12, 1'b1, 1'b0, 5'd0},
      '{KIND_LOAD,   ROTOR_SLOW,   5'd13, 5'd0,  5'd0,  1'b1, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd1,  1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd24, 1'b0, 1'b0, 5'd0},
      '{KIND_LETTER, ROTOR_FAST,   5'd0,  5'd0,  5'd2,  1'b1, 1'b0, 5'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_starts(5'd0, 5'd0, 5'd0);

    // Identity in every rotor so no letter reads an unwritten entry
    for (int i = 0; i < ALPHA; i++)
      for (int r = 0; r < 3; r++)
        send_item(KIND_LOAD, 2'(r), field_t'(i), field_t'(i), rand_field(),
                  1'($urandom_range(0, 1)), 1'b0, '0);

    foreach (dir_rows[k])
      send_item(dir_rows[k].kind, dir_rows[k].sel, dir_rows[k].idx, dir_rows[k].val,
                dir_rows[k].letter, dir_rows[k].start, dir_rows[k].typed, dir_rows[k].want);

    // Random phases, each with its own start positions
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: write_starts(5'd25, 5'd25, 5'd25);
        1: begin
          write_starts(5'd31, 5'd31, 5'd31);
          cfg_write(CFG_SPARE, 5'd17);
        end
        2: write_starts(5'd26, 5'd0, 5'd13);
        default: write_starts(rand_field(), rand_field(), rand_field());
      endcase
      sender_gaps_on = (p != 2);
      run_random_phase();
    end

    drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output checker
  always @(posedge clk) begin
    field_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      letters_out++;
      if (expected_letters.size() == 0) begin
        $error("out_letter: no letter expected, got %0d", m_axis_tdata[FIELD_W-1:0]);
        mismatch_count++;
      end else begin
        want = expected_letters.pop_front();
        if (m_axis_tdata[FIELD_W-1:0] !== want) begin
          $error("out_letter: expected %0d, got %0d", want, m_axis_tdata[FIELD_W-1:0]);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: random stalls, stretches without stalls, one long hold
  int  hold_left = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  bit  stalls_on = 1'b1;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && letters_out >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0)
        stalls_on = !stalls_on;
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = idle_length() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
hdl/trsu_pkg.sv
hdl/trsu_rotor.sv
hdl/three_rotor_substitution_unit.sv
tb/sv/three_rotor_substitution_unit_test.sv
